FILE: rtl/osc_pkg.sv
// Package: widths, codes and word types of the oblique sphere collision core.
`default_nettype none
package osc_pkg;

  // Word format of positions and velocities
  localparam int WORD_BITS   = 32;
  // Restitution register format
  localparam int E_FRAC_BITS = 16;
  localparam int E_WIDTH     = 17;
  localparam int GAIN_BITS   = E_WIDTH + 1;
  localparam int DEN_SHIFT   = E_FRAC_BITS + 1;

  // Split of a difference magnitude into two partial-product halves
  localparam int LO_BITS  = (WORD_BITS + 1) / 2;
  localparam int SQ_BITS  = 2 * WORD_BITS;
  localparam int DD_BITS  = SQ_BITS + 2;
  localparam int DOT_BITS = SQ_BITS + 2;
  // Split of |dot| for the gain product
  localparam int GLO_BITS = (DOT_BITS + 1) / 2;
  localparam int GHI_BITS = DOT_BITS - GLO_BITS;
  localparam int P_BITS   = DOT_BITS + GAIN_BITS;
  // Split of |dot|*gain into three chunks for the per-axis product
  localparam int CW_BITS  = (P_BITS + 2) / 3;
  localparam int NUM_BITS = P_BITS + WORD_BITS;
  localparam int DEN_BITS = DD_BITS + DEN_SHIFT;
  // Quotient magnitude stays below 2^(WORD_BITS+2)
  localparam int Q_BITS   = WORD_BITS + 2;

  // Configuration port
  localparam int ADDR_BITS = 2;
  localparam logic [ADDR_BITS-1:0] REG_RESTITUTION = 2'd0;
  localparam logic [E_WIDTH-1:0] RESTITUTION_RESET = {1'b1, {E_FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic signed [WORD_BITS-1:0] a_px;
    logic signed [WORD_BITS-1:0] a_py;
    logic signed [WORD_BITS-1:0] a_pz;
    logic signed [WORD_BITS-1:0] b_px;
    logic signed [WORD_BITS-1:0] b_py;
    logic signed [WORD_BITS-1:0] b_pz;
    logic signed [WORD_BITS-1:0] a_vx;
    logic signed [WORD_BITS-1:0] a_vy;
    logic signed [WORD_BITS-1:0] a_vz;
    logic signed [WORD_BITS-1:0] b_vx;
    logic signed [WORD_BITS-1:0] b_vy;
    logic signed [WORD_BITS-1:0] b_vz;
  } pair_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] new_a_vx;
    logic signed [WORD_BITS-1:0] new_a_vy;
    logic signed [WORD_BITS-1:0] new_a_vz;
    logic signed [WORD_BITS-1:0] new_b_vx;
    logic signed [WORD_BITS-1:0] new_b_vy;
    logic signed [WORD_BITS-1:0] new_b_vz;
    logic                        centres_coincide;
  } result_t;

  // One slot of the divider pipeline: three lanes share one denominator
  typedef struct packed {
    logic [2:0][NUM_BITS-1:0]  rem;
    logic [2:0][Q_BITS-1:0]    q;
    logic [2:0]                sgn;
    logic [DEN_BITS-1:0]       den;
    logic [2:0][WORD_BITS-1:0] av;
    logic [2:0][WORD_BITS-1:0] bv;
    logic                      zero;
  } div_t;

endpackage
`default_nettype wire

FILE: rtl/osc_div_pipe.sv
// Restoring divider pipeline: one quotient bit per stage for three lanes.
`default_nettype none
module osc_div_pipe
  import osc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic up_valid,
  output logic      up_ready,
  input  wire div_t up_word,
  output logic      dn_valid,
  input  wire logic dn_ready,
  output div_t      dn_word
);

  div_t             st [Q_BITS];
  div_t             pv [Q_BITS];
  div_t             nx [Q_BITS];
  logic [Q_BITS-1:0] vld;
  logic [Q_BITS-1:0] en;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[Q_BITS-1] = ~vld[Q_BITS-1] | dn_ready;
    for (int k = Q_BITS - 2; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = vld[Q_BITS-1];
  assign dn_word  = st[Q_BITS-1];

  for (genvar i = 0; i < Q_BITS; i++) begin : g_stage
    localparam int B = Q_BITS - 1 - i;

    if (i == 0) begin : g_first
      assign pv[i] = up_word;
    end else begin : g_rest
      assign pv[i] = st[i-1];
    end

    // Subtract the shifted denominator where it fits, set the quotient bit
    always_comb begin
      logic [NUM_BITS-1:0] t;
      t = NUM_BITS'(pv[i].den) << B;
      nx[i] = pv[i];
      for (int c = 0; c < 3; c++) begin
        if (pv[i].rem[c] >= t) begin
          nx[i].rem[c]  = pv[i].rem[c] - t;
          nx[i].q[c][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en[i]) begin
        vld[i] <= (i == 0) ? up_valid : vld[(i == 0) ? 0 : i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        st[i] <= nx[i];
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/oblique_sphere_collision_core.sv
// Top level: oblique collision of two equal-mass spheres with restitution.
//
//  channel  direction  handshake                 word
//  pair     in         pair_valid / pair_ready   pair_t (centres, velocities)
//  res      out        res_valid / res_ready     result_t (velocities, flag)
//  config   in         APB psel/penable/pwrite   restitution at byte address 0
//
// One word enters per cycle while the output is not stalled; the path holds nine
// arithmetic stages, 34 divider stages (one quotient bit each), and the output register.
// The divider pipeline, one compare-subtract per bit, sets the depth.
// Reset (rst, synchronous) empties the pipeline and loads restitution 1.0.
// A stalled output holds its word; each stage still fills while empty.
`default_nettype none
module oblique_sphere_collision_core
  import osc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 pair_valid,
  output logic                      pair_ready,
  input  wire pair_t                pair,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output result_t                   res,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int W  = WORD_BITS;
  localparam int LO = LO_BITS;
  localparam int NS = 9;

  typedef struct packed {
    logic [2:0][W-1:0] dm;
    logic [2:0][W-1:0] vm;
    logic [2:0]        ds;
    logic [2:0]        vs;
    logic [2:0][W-1:0] av;
    logic [2:0][W-1:0] bv;
  } s0_t;

  typedef struct packed {
    logic [2:0][2*LO-1:0] sll;
    logic [2:0][2*LO-1:0] slh;
    logic [2:0][2*LO-1:0] shh;
    logic [2:0][2*LO-1:0] pll;
    logic [2:0][2*LO-1:0] plh;
    logic [2:0][2*LO-1:0] phl;
    logic [2:0][2*LO-1:0] phh;
    logic [2:0]           ps;
    logic [2:0]           ds;
    logic [2:0][W-1:0]    dm;
    logic                 zero;
    logic [2:0][W-1:0]    av;
    logic [2:0][W-1:0]    bv;
  } s1_t;

  typedef struct packed {
    logic [2:0][SQ_BITS-1:0] sq;
    logic [2:0][SQ_BITS-1:0] pr;
    logic [2:0]              ps;
    logic [2:0]              ds;
    logic [2:0][W-1:0]       dm;
    logic                    zero;
    logic [2:0][W-1:0]       av;
    logic [2:0][W-1:0]       bv;
  } s2_t;

  typedef struct packed {
    logic [DD_BITS-1:0]       dd;
    logic signed [DOT_BITS:0] dot;
    logic [2:0]               ds;
    logic [2:0][W-1:0]        dm;
    logic                     zero;
    logic [2:0][W-1:0]        av;
    logic [2:0][W-1:0]        bv;
  } s3_t;

  typedef struct packed {
    logic [DEN_BITS-1:0] den;
    logic [DOT_BITS-1:0] dotm;
    logic                dots;
    logic [2:0]          ds;
    logic [2:0][W-1:0]   dm;
    logic                zero;
    logic [2:0][W-1:0]   av;
    logic [2:0][W-1:0]   bv;
  } s4_t;

  typedef struct packed {
    logic [GLO_BITS+GAIN_BITS-1:0] gl;
    logic [GLO_BITS+GAIN_BITS-1:0] gh;
    logic [DEN_BITS-1:0]           den;
    logic                          dots;
    logic [2:0]                    ds;
    logic [2:0][W-1:0]             dm;
    logic                          zero;
    logic [2:0][W-1:0]             av;
    logic [2:0][W-1:0]             bv;
  } s5_t;

  typedef struct packed {
    logic [P_BITS-1:0]   p;
    logic [DEN_BITS-1:0] den;
    logic                dots;
    logic [2:0]          ds;
    logic [2:0][W-1:0]   dm;
    logic                zero;
    logic [2:0][W-1:0]   av;
    logic [2:0][W-1:0]   bv;
  } s6_t;

  typedef struct packed {
    logic [2:0][2:0][1:0][CW_BITS+LO-1:0] part;
    logic [DEN_BITS-1:0]                  den;
    logic [2:0]                           sgn;
    logic                                 zero;
    logic [2:0][W-1:0]                    av;
    logic [2:0][W-1:0]                    bv;
  } s7_t;

  logic [E_WIDTH-1:0] restitution;
  logic [NS-1:0]      vld;
  logic [NS-1:0]      en;
  logic               div_ready;
  logic               div_valid;
  div_t               div_word;
  logic               res_en;
  result_t            res_next;

  s0_t  s0, s0_next;
  s1_t  s1, s1_next;
  s2_t  s2, s2_next;
  s3_t  s3, s3_next;
  s4_t  s4, s4_next;
  s5_t  s5, s5_next;
  s6_t  s6, s6_next;
  s7_t  s7, s7_next;
  div_t s8, s8_next;

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= RESTITUTION_RESET;
    end else if (psel && penable && pwrite && paddr == REG_RESTITUTION) begin
      restitution <= pwdata[E_WIDTH-1:0];
    end
  end
  assign prdata = (paddr == REG_RESTITUTION) ? 32'(restitution) : 32'd0;

  // Stage enables: advance when empty or when the next stage advances
  always_comb begin
    en[NS-1] = ~vld[NS-1] | div_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end
  assign pair_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= pair_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 0: differences as sign and magnitude
  always_comb begin
    logic [2:0][W-1:0] ap, bp;
    logic signed [W:0] d, v;
    ap = {pair.a_pz, pair.a_py, pair.a_px};
    bp = {pair.b_pz, pair.b_py, pair.b_px};
    s0_next.av = {pair.a_vz, pair.a_vy, pair.a_vx};
    s0_next.bv = {pair.b_vz, pair.b_vy, pair.b_vx};
    for (int c = 0; c < 3; c++) begin
      d = $signed({bp[c][W-1], bp[c]}) - $signed({ap[c][W-1], ap[c]});
      v = $signed({s0_next.bv[c][W-1], s0_next.bv[c]})
        - $signed({s0_next.av[c][W-1], s0_next.av[c]});
      s0_next.ds[c] = d[W];
      s0_next.vs[c] = v[W];
      s0_next.dm[c] = d[W] ? W'(-d) : d[W-1:0];
      s0_next.vm[c] = v[W] ? W'(-v) : v[W-1:0];
    end
  end

  // Stage 1: half-width partial products of d*d and dv*d
  always_comb begin
    logic [LO-1:0] dl, dh, vl, vh;
    s1_next.ds   = s0.ds;
    s1_next.dm   = s0.dm;
    s1_next.av   = s0.av;
    s1_next.bv   = s0.bv;
    s1_next.zero = (s0.dm == '0);
    for (int c = 0; c < 3; c++) begin
      dl = s0.dm[c][LO-1:0];
      dh = LO'(s0.dm[c][W-1:LO]);
      vl = s0.vm[c][LO-1:0];
      vh = LO'(s0.vm[c][W-1:LO]);
      s1_next.sll[c] = dl * dl;
      s1_next.slh[c] = dl * dh;
      s1_next.shh[c] = dh * dh;
      s1_next.pll[c] = vl * dl;
      s1_next.plh[c] = vl * dh;
      s1_next.phl[c] = vh * dl;
      s1_next.phh[c] = vh * dh;
      s1_next.ps[c]  = s0.ds[c] ^ s0.vs[c];
    end
  end

  // Stage 2: assemble the full products
  always_comb begin
    s2_next.ps   = s1.ps;
    s2_next.ds   = s1.ds;
    s2_next.dm   = s1.dm;
    s2_next.zero = s1.zero;
    s2_next.av   = s1.av;
    s2_next.bv   = s1.bv;
    for (int c = 0; c < 3; c++) begin
      s2_next.sq[c] = (SQ_BITS'(s1.shh[c]) << (2 * LO))
                    + (SQ_BITS'(s1.slh[c]) << (LO + 1))
                    + SQ_BITS'(s1.sll[c]);
      s2_next.pr[c] = (SQ_BITS'(s1.phh[c]) << (2 * LO))
                    + ((SQ_BITS'(s1.plh[c]) + SQ_BITS'(s1.phl[c])) << LO)
                    + SQ_BITS'(s1.pll[c]);
    end
  end

  // Stage 3: |d|^2 and the signed dot product
  always_comb begin
    logic signed [DOT_BITS:0] t;
    s3_next.ds   = s2.ds;
    s3_next.dm   = s2.dm;
    s3_next.zero = s2.zero;
    s3_next.av   = s2.av;
    s3_next.bv   = s2.bv;
    s3_next.dd   = DD_BITS'(s2.sq[0]) + DD_BITS'(s2.sq[1]) + DD_BITS'(s2.sq[2]);
    s3_next.dot  = '0;
    for (int c = 0; c < 3; c++) begin
      t = (DOT_BITS + 1)'(s2.pr[c]);
      if (s2.ps[c]) t = -t;
      s3_next.dot = s3_next.dot + t;
    end
  end

  // Stage 4: dot magnitude, scaled denominator
  always_comb begin
    s4_next.dots = s3.dot[DOT_BITS];
    s4_next.dotm = s3.dot[DOT_BITS] ? DOT_BITS'(-s3.dot) : s3.dot[DOT_BITS-1:0];
    s4_next.den  = {s3.dd, {DEN_SHIFT{1'b0}}};
    s4_next.ds   = s3.ds;
    s4_next.dm   = s3.dm;
    s4_next.zero = s3.zero;
    s4_next.av   = s3.av;
    s4_next.bv   = s3.bv;
  end

  // Stage 5: |dot| times (1 + e), in two halves
  always_comb begin
    logic [GAIN_BITS-1:0] gain;
    gain = (GAIN_BITS'(1) << E_FRAC_BITS) + GAIN_BITS'(restitution);
    s5_next.gl   = s4.dotm[GLO_BITS-1:0] * gain;
    s5_next.gh   = GLO_BITS'(s4.dotm[DOT_BITS-1:GLO_BITS]) * gain;
    s5_next.den  = s4.den;
    s5_next.dots = s4.dots;
    s5_next.ds   = s4.ds;
    s5_next.dm   = s4.dm;
    s5_next.zero = s4.zero;
    s5_next.av   = s4.av;
    s5_next.bv   = s4.bv;
  end

  // Stage 6: join the gain halves
  always_comb begin
    s6_next.p    = P_BITS'(s5.gl) + (P_BITS'(s5.gh) << GLO_BITS);
    s6_next.den  = s5.den;
    s6_next.dots = s5.dots;
    s6_next.ds   = s5.ds;
    s6_next.dm   = s5.dm;
    s6_next.zero = s5.zero;
    s6_next.av   = s5.av;
    s6_next.bv   = s5.bv;
  end

  // Stage 7: per-axis numerator partial products
  always_comb begin
    logic [3*CW_BITS-1:0] pp;
    logic [LO-1:0]        dl, dh;
    pp = (3 * CW_BITS)'(s6.p);
    for (int c = 0; c < 3; c++) begin
      dl = s6.dm[c][LO-1:0];
      dh = LO'(s6.dm[c][W-1:LO]);
      for (int k = 0; k < 3; k++) begin
        s7_next.part[c][k][0] = pp[k*CW_BITS +: CW_BITS] * dl;
        s7_next.part[c][k][1] = pp[k*CW_BITS +: CW_BITS] * dh;
      end
      s7_next.sgn[c] = s6.dots ^ s6.ds[c];
    end
    s7_next.den  = s6.den;
    s7_next.zero = s6.zero;
    s7_next.av   = s6.av;
    s7_next.bv   = s6.bv;
  end

  // Stage 8: numerator sums, load the divider word
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s8_next.rem[c] = '0;
      for (int k = 0; k < 3; k++) begin
        for (int h = 0; h < 2; h++) begin
          s8_next.rem[c] = s8_next.rem[c]
                         + (NUM_BITS'(s7.part[c][k][h]) << (k * CW_BITS + h * LO));
        end
      end
    end
    s8_next.q    = '0;
    s8_next.sgn  = s7.sgn;
    s8_next.den  = s7.den;
    s8_next.av   = s7.av;
    s8_next.bv   = s7.bv;
    s8_next.zero = s7.zero;
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (en[0]) s0 <= s0_next;
    if (en[1]) s1 <= s1_next;
    if (en[2]) s2 <= s2_next;
    if (en[3]) s3 <= s3_next;
    if (en[4]) s4 <= s4_next;
    if (en[5]) s5 <= s5_next;
    if (en[6]) s6 <= s6_next;
    if (en[7]) s7 <= s7_next;
    if (en[8]) s8 <= s8_next;
  end

  osc_div_pipe u_div (
    .clk      (clk),
    .rst      (rst),
    .up_valid (vld[NS-1]),
    .up_ready (div_ready),
    .up_word  (s8),
    .dn_valid (div_valid),
    .dn_ready (res_en),
    .dn_word  (div_word)
  );

  // Clamp a widened sum to the signed word range
  function automatic logic [W-1:0] sat_word(input logic signed [W+3:0] x);
    if (x[W+3:W-1] == '0 || x[W+3:W-1] == '1) begin
      return x[W-1:0];
    end else begin
      return x[W+3] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  // Apply the correction to both spheres, or pass them on coinciding centres
  always_comb begin
    logic signed [Q_BITS:0]   dl;
    logic signed [W+3:0]      a, b;
    logic [2:0][W-1:0]        na, nb;
    for (int c = 0; c < 3; c++) begin
      dl = $signed({1'b0, div_word.q[c]});
      if (div_word.sgn[c]) dl = -dl;
      a = $signed({{4{div_word.av[c][W-1]}}, div_word.av[c]}) + (W + 4)'(dl);
      b = $signed({{4{div_word.bv[c][W-1]}}, div_word.bv[c]}) - (W + 4)'(dl);
      na[c] = div_word.zero ? div_word.av[c] : sat_word(a);
      nb[c] = div_word.zero ? div_word.bv[c] : sat_word(b);
    end
    res_next.new_a_vx         = na[0];
    res_next.new_a_vy         = na[1];
    res_next.new_a_vz         = na[2];
    res_next.new_b_vx         = nb[0];
    res_next.new_b_vy         = nb[1];
    res_next.new_b_vz         = nb[2];
    res_next.centres_coincide = div_word.zero;
  end

  // Output register
  assign res_en = ~res_valid | res_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_en) begin
      res_valid <= div_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (res_en) res <= res_next;
  end

endmodule
`default_nettype wire

FILE: bench/collision_checker.sv
// Checker: predicts post-collision velocities and compares each result word.
module collision_checker
  import osc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pair_valid,
  input  logic                 pair_ready,
  input  pair_t                pair,
  input  logic                 res_valid,
  input  logic                 res_ready,
  input  result_t              res,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] big_t;

  localparam int FIELDS = 7;

  result_t              expected_velocities[$];
  logic [E_WIDTH-1:0]   restitution_copy;
  int                   mismatch_count;

  // Clamp a wide value to the signed word range
  function automatic logic signed [WORD_BITS-1:0] sat_word(big_t v);
    big_t hi;
    big_t lo;
    hi = (big_t'(1) <<< (WORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[WORD_BITS-1:0];
  endfunction

  // Resolve the collision exactly, one truncation per axis
  function automatic result_t predict_velocities(pair_t p, logic [E_WIDTH-1:0] e);
    big_t    ap[3], bp[3], av[3], bv[3], d[3];
    big_t    dd, dot, gain, den, num, q, lim;
    result_t r;
    ap[0] = p.a_px; ap[1] = p.a_py; ap[2] = p.a_pz;
    bp[0] = p.b_px; bp[1] = p.b_py; bp[2] = p.b_pz;
    av[0] = p.a_vx; av[1] = p.a_vy; av[2] = p.a_vz;
    bv[0] = p.b_vx; bv[1] = p.b_vy; bv[2] = p.b_vz;
    dd  = 0;
    dot = 0;
    for (int c = 0; c < 3; c++) begin
      d[c] = bp[c] - ap[c];
      dd   = dd + d[c] * d[c];
      dot  = dot + (bv[c] - av[c]) * d[c];
    end
    r.centres_coincide = (dd == 0);
    if (dd == 0) begin
      r.new_a_vx = p.a_vx; r.new_a_vy = p.a_vy; r.new_a_vz = p.a_vz;
      r.new_b_vx = p.b_vx; r.new_b_vy = p.b_vy; r.new_b_vz = p.b_vz;
      return r;
    end
    gain = (big_t'(1) <<< E_FRAC_BITS) + big_t'({1'b0, e});
    den  = dd * (big_t'(1) <<< (E_FRAC_BITS + 1));
    lim  = big_t'(1) <<< 60;
    for (int c = 0; c < 3; c++) begin
      num = dot * gain * d[c];
      q   = num / den;
      if (q > lim) q = lim;
      if (q < -lim) q = -lim;
      av[c] = av[c] + q;
      bv[c] = bv[c] - q;
    end
    r.new_a_vx = sat_word(av[0]); r.new_a_vy = sat_word(av[1]);
    r.new_a_vz = sat_word(av[2]);
    r.new_b_vx = sat_word(bv[0]); r.new_b_vy = sat_word(bv[1]);
    r.new_b_vz = sat_word(bv[2]);
    return r;
  endfunction

  assign pending = expected_velocities.size();

  always @(posedge clk) begin
    result_t                    want;
    logic [FIELDS-1:0][31:0]    exp_f;
    logic [FIELDS-1:0][31:0]    act_f;
    if (rst) begin
      restitution_copy <= RESTITUTION_RESET;
      fail_count       <= 0;
      mismatch_count   <= 0;
      expected_velocities.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready && paddr == REG_RESTITUTION)
        restitution_copy <= pwdata[E_WIDTH-1:0];
      // Predict each accepted pair word
      if (pair_valid && pair_ready)
        expected_velocities.insert(expected_velocities.size(),
                                   predict_velocities(pair, restitution_copy));
      // Compare each accepted result word against the oldest prediction
      if (res_valid && res_ready) begin
        if (expected_velocities.size() == 0) begin
          fail_count <= fail_count + 1;
          if (mismatch_count < 10)
            $display("unexpected result word %h", res);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want  = expected_velocities.pop_front();
          exp_f = {want.new_a_vx, want.new_a_vy, want.new_a_vz, want.new_b_vx,
                   want.new_b_vy, want.new_b_vz, 31'd0, want.centres_coincide};
          act_f = {res.new_a_vx, res.new_a_vy, res.new_a_vz, res.new_b_vx,
                   res.new_b_vy, res.new_b_vz, 31'd0, res.centres_coincide};
          if (exp_f != act_f) begin
            fail_count <= fail_count + 1;
            if (mismatch_count < 10)
              for (int f = FIELDS - 1; f >= 0; f--)
                if (exp_f[f] != act_f[f])
                  $display("field %0d: expected %h got %h", FIELDS - 1 - f,
                           exp_f[f], act_f[f]);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: bench/testbench.sv
// Testbench top: drives pairs and register writes, gives the verdict.
module testbench;
  import osc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 60;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pair_valid = 1'b0;
  logic                 pair_ready;
  pair_t                pair = '0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  result_t              res;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  int                   fail_count;
  int                   pending;
  int                   cycle_count = 0;
  bit                   calm = 1'b0;
  int                   stall_left = 0;

  oblique_sphere_collision_core dut (.*);

  collision_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // End the run on a hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("oblique_sphere_collision_core: mismatch");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Stall the result side at random
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_ready  <= 1'b0;
    end else begin
      res_ready  <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Random word: full range, small magnitude, or an extreme
  function automatic logic [31:0] rand_word(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
      default: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int    r;
    int    mode;
    r    = $urandom_range(0, 99);
    mode = (r < 55) ? 1 : (r < 90) ? 0 : 2;
    p = {rand_word(mode), rand_word(mode), rand_word(mode), rand_word(mode),
         rand_word(mode), rand_word(mode), rand_word(mode), rand_word(mode),
         rand_word(mode), rand_word(mode), rand_word(mode), rand_word(mode)};
    // Coinciding centres now and then
    if ($urandom_range(0, 19) == 0) begin
      p.b_px = p.a_px; p.b_py = p.a_py; p.b_pz = p.a_pz;
    end
    return p;
  endfunction

  task automatic send_pair(pair_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pair_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pair       <= p;
    pair_valid <= 1'b1;
    @(posedge clk);
    while (!pair_ready) @(posedge clk);
  endtask

  task automatic drain();
    pair_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_restitution(logic [31:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_RESTITUTION;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_directed();
    pair_t p;
    // Extremes of every field
    send_pair('1);
    send_pair('0);
    p = {12{32'h7fff_ffff}}; send_pair(p);
    p = {12{32'h8000_0000}}; send_pair(p);
    p = {{6{32'h8000_0000}}, {6{32'h7fff_ffff}}}; send_pair(p);
    p = '0; p.b_px = 32'h7fff_ffff; p.a_px = 32'h8000_0000;
    p.a_vx = 32'h7fff_ffff; p.b_vx = 32'h8000_0000; send_pair(p);
    // Head-on approach along x
    p = '0; p.b_px = 32'h0002_0000; p.a_vx = 32'h0001_0000; send_pair(p);
    // Separating along x
    p = '0; p.b_px = 32'h0002_0000; p.a_vx = 32'hffff_0000; send_pair(p);
    // Oblique with tangential parts
    p = '0; p.b_px = 32'h0001_0000; p.b_py = 32'h0001_0000;
    p.a_vx = 32'h0003_0000; p.a_vz = 32'h0000_8000; p.b_vy = 32'hfffe_0000;
    send_pair(p);
    // Coinciding centres with moving spheres
    p = rand_pair(); p.b_px = p.a_px; p.b_py = p.a_py; p.b_pz = p.a_pz;
    send_pair(p);
    // Tiny separation, huge velocities
    p = '0; p.b_pz = 32'd1; p.a_vz = 32'h7fff_ffff; p.b_vz = 32'h8000_0000;
    send_pair(p);
  endtask

  initial begin
    logic [31:0] settings[5];
    settings = '{32'd65536, 32'd0, 32'd32768, 32'd131071, 32'd0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_directed();
    for (int s = 0; s < 5; s++) begin
      write_restitution((s == 4) ? $urandom_range(0, 65536) : settings[s]);
      if (s < 2) send_directed();
      calm = (s == 2);
      repeat (226) send_pair(rand_pair());
      calm = 1'b0;
    end
    drain();
    if (fail_count == 0) begin
      $display("oblique_sphere_collision_core: match");
    end else begin
      $display("oblique_sphere_collision_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/osc_pkg.sv
rtl/osc_div_pipe.sv
rtl/oblique_sphere_collision_core.sv
bench/collision_checker.sv
bench/testbench.sv
